// File: src/rgbamip_pkg.sv
// Shared widths, register indexes and types for the RGBA mipmap box downsampler.
package rgbamip_pkg;

    localparam int PIX_W      = 32;     // four 8-bit channels
    localparam int CH_W       = 8;
    localparam int LANE_W     = 10;     // one channel pair sum
    localparam int NUM_CH     = 4;
    localparam int SUM_W      = NUM_CH * LANE_W;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int ROW_W      = 10;
    localparam int MAX_HEIGHT = 1024;

    typedef logic [PIX_W-1:0]      t_pixel;
    typedef logic [SUM_W-1:0]      t_pair_sum;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

// File: src/rgbamip_in_if.sv
// Source pixel channel: valid/ready handshake with one pixel per beat.
interface rgbamip_in_if;
    logic                  valid;
    logic                  ready;
    rgbamip_pkg::t_pixel   pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// File: src/rgbamip_out_if.sv
// Downsampled pixel channel: valid/ready handshake with one result per beat.
interface rgbamip_out_if;
    logic                  valid;
    logic                  ready;
    rgbamip_pkg::t_pixel   averaged_pixel;
    logic                  last_of_image;

    modport source (output valid, output averaged_pixel, output last_of_image, input ready);
    modport sink   (input valid, input averaged_pixel, input last_of_image, output ready);
endinterface

// File: src/rgba_mipmap_box_downsample.sv
// 2x2 box-filter mipmap downsampler for a raster stream of RGBA8 pixels.
// Throughput: one source pixel per cycle while i_pix.ready is high; the line buffer has
// one write and one read port. The odd-row pixel that closes a result fills the result
// stage, then the output register. A held output blocks input once that stage is full.
// Reset (synchronous, active low) clears counters, held pixel, handshake state and sets
// width and height to 64; the line buffer is not cleared, even rows fill it before use.
module rgba_mipmap_box_downsample #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rgbamip_in_if.sink                         i_pix,
    rgbamip_out_if.source                      o_avg,
    input  logic                               i_cfg_wr_en,
    input  logic [rgbamip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  rgbamip_pkg::t_cfg_data             i_cfg_data
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int EW         = (($clog2(MAX_WIDTH + 1) > rgbamip_pkg::CFG_DATA_W) ?
                                 $clog2(MAX_WIDTH + 1) : rgbamip_pkg::CFG_DATA_W) + 1;
    localparam int HW         = rgbamip_pkg::CFG_DATA_W + 1;
    localparam int LW         = rgbamip_pkg::LANE_W;
    localparam int CW         = rgbamip_pkg::CH_W;

    // configuration
    rgbamip_pkg::t_cfg_data r_img_width;
    rgbamip_pkg::t_cfg_data r_img_height;

    // stream position and pair state
    logic [COL_W-1:0]              r_col;
    logic [rgbamip_pkg::ROW_W-1:0] r_row;
    rgbamip_pkg::t_pixel           r_held;

    // line buffer of pair sums from the even row
    rgbamip_pkg::t_pair_sum r_line [LINE_DEPTH];
    rgbamip_pkg::t_pair_sum r_above;

    // result stage and output register
    logic                   r_s1_v;
    rgbamip_pkg::t_pair_sum r_s1_ps;
    logic                   r_s1_last;
    logic                   r_out_v;
    rgbamip_pkg::t_pixel    r_out_pix;
    logic                   r_out_last;

    logic [EW-1:0]          w_width;
    logic [EW-1:0]          w_wtmp;
    logic [HW-1:0]          w_height;
    logic [EW-1:0]          w_col_nxt;
    logic [HW-1:0]          w_row_nxt;
    logic                   w_accept;
    logic                   w_active;
    logic                   w_pair_end;
    logic                   w_wr;
    logic                   w_emit;
    logic                   w_last;
    logic                   w_adv;
    logic [ADDR_W-1:0]      w_addr;
    rgbamip_pkg::t_pair_sum w_ps;
    rgbamip_pkg::t_pixel    w_avg;
    logic [LW:0]            w_lane;

    // clamp the programmed size to the supported range
    always_comb begin
        w_wtmp = EW'({r_img_width[rgbamip_pkg::CFG_DATA_W-1:1], 1'b0});
        if (w_wtmp < EW'(2)) begin
            w_width = EW'(2);
        end else if (w_wtmp > EW'(MAX_WIDTH)) begin
            w_width = EW'(MAX_WIDTH) & ~EW'(1);
        end else begin
            w_width = w_wtmp;
        end
        if (r_img_height == '0) begin
            w_height = HW'(1);
        end else if (HW'(r_img_height) > HW'(rgbamip_pkg::MAX_HEIGHT)) begin
            w_height = HW'(rgbamip_pkg::MAX_HEIGHT);
        end else begin
            w_height = HW'(r_img_height);
        end
    end

    // handshake: the result stage drains into the output register
    assign w_adv       = r_s1_v && (!r_out_v || o_avg.ready);
    assign i_pix.ready = !r_s1_v || w_adv;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // classify the current beat
    assign w_col_nxt  = EW'(r_col) + EW'(1);
    assign w_row_nxt  = HW'(r_row) + HW'(1);
    assign w_active   = (EW'(r_col) < w_width) && (HW'(r_row) < w_height);
    assign w_pair_end = w_active && r_col[0];
    assign w_wr       = w_accept && w_pair_end && !r_row[0];
    assign w_emit     = w_accept && w_pair_end && r_row[0];
    assign w_last     = (w_col_nxt == w_width) && (w_row_nxt == (w_height & ~HW'(1)));
    assign w_addr     = ADDR_W'(r_col >> 1);

    // per-channel sum of the held pixel and this one
    always_comb begin
        for (int c = 0; c < rgbamip_pkg::NUM_CH; c++) begin
            w_ps[c*LW +: LW] = LW'(r_held[c*CW +: CW]) + LW'(i_pix.pixel_value[c*CW +: CW]);
        end
    end

    // add the row above and divide by four, truncating
    always_comb begin
        w_lane = '0;
        for (int c = 0; c < rgbamip_pkg::NUM_CH; c++) begin
            w_lane = (LW+1)'(r_above[c*LW +: LW]) + (LW+1)'(r_s1_ps[c*LW +: LW]);
            w_avg[c*CW +: CW] = w_lane[CW+1:2];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= rgbamip_pkg::CFG_DATA_W'(64);
            r_img_height <= rgbamip_pkg::CFG_DATA_W'(64);
        end else if (i_cfg_wr_en) begin
            unique case (rgbamip_pkg::t_cfg_reg'(i_cfg_index))
                rgbamip_pkg::CFG_IMAGE_WIDTH:  r_img_width  <= i_cfg_data;
                rgbamip_pkg::CFG_IMAGE_HEIGHT: r_img_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance column and row, wrap at or past the bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (w_accept) begin
            if (w_active && !r_col[0]) begin
                r_held <= i_pix.pixel_value;
            end
            if (w_col_nxt >= w_width) begin
                r_col <= '0;
                r_row <= (w_row_nxt >= w_height) ? '0 : rgbamip_pkg::ROW_W'(w_row_nxt);
            end else begin
                r_col <= COL_W'(w_col_nxt);
            end
        end
    end

    // line buffer: even rows write, odd rows read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_line[w_addr] <= w_ps;
        end
        if (w_emit) begin
            r_above <= r_line[w_addr];
        end
    end

    // result stage: hold the pair sum until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_emit) begin
            r_s1_v <= 1'b1;
        end else if (w_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_ps   <= w_ps;
            r_s1_last <= w_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (o_avg.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pix  <= w_avg;
            r_out_last <= r_s1_last;
        end
    end

    assign o_avg.valid          = r_out_v;
    assign o_avg.averaged_pixel = r_out_pix;
    assign o_avg.last_of_image  = r_out_last;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the RGBA 2x2 box-filter mipmap downsampler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = 1024;
    localparam int LINE_DEPTH     = MAX_W / 2;
    localparam int RANDOM_ITEMS   = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        rgbamip_pkg::t_pixel avg;
        logic                last;
    } t_down_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              cfg_wr_en;
    logic [rgbamip_pkg::CFG_IDX_W-1:0] cfg_index;
    rgbamip_pkg::t_cfg_data            cfg_data;

    rgbamip_in_if  pix_if ();
    rgbamip_out_if avg_if ();

    rgba_mipmap_box_downsample dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_avg       (avg_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow of the downsampler: registers, line of pair sums, counters
    rgbamip_pkg::t_cfg_data width_reg = 11'd64;
    rgbamip_pkg::t_cfg_data height_reg = 11'd64;
    rgbamip_pkg::t_pair_sum pair_line [LINE_DEPTH];
    rgbamip_pkg::t_pixel    held_px = '0;
    int unsigned            col_cnt = 0;
    int unsigned            row_cnt = 0;

    rgbamip_pkg::t_pixel    pixel_backlog [$];
    t_down_result           pending_averages [$];

    bit           pix_accepted = 1'b0;
    bit           steady_flow = 1'b0;
    bit           hold_kick = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  mismatches = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_width(rgbamip_pkg::t_cfg_data r);
        int unsigned w;
        w = 32'(r & 11'h7FE);
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height(rgbamip_pkg::t_cfg_data r);
        int unsigned h;
        h = 32'(r);
        if (h < 1) h = 1;
        if (h > rgbamip_pkg::MAX_HEIGHT) h = rgbamip_pkg::MAX_HEIGHT;
        return h;
    endfunction

    // Advance the shadow by one source pixel; queue the average it closes, if any
    task automatic box_filter_step(rgbamip_pkg::t_pixel px);
        int unsigned            w, h, idx;
        rgbamip_pkg::t_pair_sum ps;
        logic [10:0]            lane_total;
        t_down_result           res;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        if (col_cnt < w && row_cnt < h) begin
            if (col_cnt % 2 == 0) begin
                held_px = px;
            end else begin
                idx = col_cnt / 2;
                for (int c = 0; c < rgbamip_pkg::NUM_CH; c++)
                    ps[c*rgbamip_pkg::LANE_W +: rgbamip_pkg::LANE_W] =
                        rgbamip_pkg::LANE_W'(held_px[c*rgbamip_pkg::CH_W +: rgbamip_pkg::CH_W])
                      + rgbamip_pkg::LANE_W'(px[c*rgbamip_pkg::CH_W +: rgbamip_pkg::CH_W]);
                if (row_cnt % 2 == 0) begin
                    pair_line[idx] = ps;
                end else begin
                    for (int c = 0; c < rgbamip_pkg::NUM_CH; c++) begin
                        lane_total =
                            11'(pair_line[idx][c*rgbamip_pkg::LANE_W +: rgbamip_pkg::LANE_W])
                          + 11'(ps[c*rgbamip_pkg::LANE_W +: rgbamip_pkg::LANE_W]);
                        res.avg[c*rgbamip_pkg::CH_W +: rgbamip_pkg::CH_W] = lane_total[9:2];
                    end
                    res.last = (col_cnt + 1 == w) && (row_cnt + 1 == (h & ~1));
                    pending_averages.push_back(res);
                end
            end
        end
        // wrap at or past the bounds, as the block does after a mid-image write
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        col_cnt &= 32'h3FF;
        row_cnt &= 32'h3FF;
    endtask

    // Driver: offer the next pixel once the previous beat is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_accepted) begin
            if (pixel_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 6)) begin
                pix_if.valid       <= 1'b1;
                pix_if.pixel_value <= pixel_backlog.pop_front();
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold when kicked
    always @(negedge i_clk) begin
        if (hold_kick && hold_left == 0) begin
            hold_left    <= HOLD_CYCLES;
            avg_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            avg_if.ready <= 1'b0;
        end else begin
            avg_if.ready <= steady_flow || ($urandom_range(99) >= 6);
        end
    end

    // Monitor: predict on every input beat, check every output beat
    always @(posedge i_clk) begin : monitor
        t_down_result want, seen;
        pix_accepted <= i_rst_n && pix_if.valid && pix_if.ready;
        if (i_rst_n && pix_if.valid && pix_if.ready)
            box_filter_step(pix_if.pixel_value);
        if (i_rst_n && avg_if.valid && avg_if.ready) begin
            seen.avg  = avg_if.averaged_pixel;
            seen.last = avg_if.last_of_image;
            if (pending_averages.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: avg %h last %b", seen.avg, seen.last);
            end else begin
                want = pending_averages.pop_front();
                if (want.avg !== seen.avg || want.last !== seen.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected avg %h last %b, got avg %h last %b",
                                 want.avg, want.last, seen.avg, seen.last);
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (avg_if.valid && avg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(rgbamip_pkg::t_cfg_reg idx, rgbamip_pkg::t_cfg_data value);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == rgbamip_pkg::CFG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic rgbamip_pkg::t_pixel random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {4{8'($urandom_range(255))}};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_pixels(int unsigned count);
        @(posedge i_clk);
        repeat (count) pixel_backlog.push_back(random_pixel());
    endtask

    // Wait for the backlog and all expected results to clear, then let the pipe settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_backlog.size() != 0 || pix_if.valid || pending_averages.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_image(rgbamip_pkg::t_cfg_data w_reg, rgbamip_pkg::t_cfg_data h_reg);
        write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, w_reg);
        write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, h_reg);
        queue_pixels(eff_width(w_reg) * eff_height(h_reg));
        wait_drained();
    endtask

    initial begin : stimulus
        int unsigned            random_items;
        int unsigned            img;
        int unsigned            pick;
        rgbamip_pkg::t_cfg_data w_reg, h_reg;

        i_rst_n            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = rgbamip_pkg::CFG_IMAGE_WIDTH;
        cfg_data           = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        avg_if.ready       = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width, two rows; hold the output long enough to back up the input
        write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        queue_pixels(eff_width(width_reg) * 2);
        while (pixel_backlog.size() > 40) @(posedge i_clk);
        hold_kick = 1'b1;
        @(posedge i_clk);
        hold_kick = 1'b0;
        wait_drained();

        // Smallest image with full-scale and zero channels; sum truncates
        write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'd2);
        write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        @(posedge i_clk);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        pixel_backlog.push_back(32'h0000_0000);
        pixel_backlog.push_back(32'hFFFF_FFFF);
        wait_drained();

        // Odd width rounds down, zero height acts as one row: no result
        run_image(11'd5, 11'd0);

        // Width shrinks mid-row: the column past the new bound wraps the row
        write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'd8);
        write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        queue_pixels(6);
        wait_drained();
        write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'd4);
        queue_pixels(5);
        wait_drained();

        // Height shrinks below the current row: that row is dropped, image restarts
        write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'd2);
        write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        queue_pixels(4);
        wait_drained();
        write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        queue_pixels(2);
        wait_drained();

        // Random images, mostly small, with oversized width and height once each
        random_items = 0;
        for (img = 0; random_items < RANDOM_ITEMS || img <= 9; img++) begin
            steady_flow = (img >= 6 && img < 10);
            if (img == 2) begin
                // Oversized width: start a row, then a narrow width wraps it
                write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(MAX_W, 2047)));
                write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd2);
                queue_pixels(4);
                wait_drained();
                write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'd2);
                queue_pixels(3);
                wait_drained();
                random_items += 7;
            end else if (img == 5) begin
                // Oversized height: two rows give a non-final result, then restart
                write_reg(rgbamip_pkg::CFG_IMAGE_WIDTH, 11'd2);
                write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT,
                          11'($urandom_range(rgbamip_pkg::MAX_HEIGHT, 2047)));
                queue_pixels(4);
                wait_drained();
                write_reg(rgbamip_pkg::CFG_IMAGE_HEIGHT, 11'd2);
                queue_pixels(2);
                wait_drained();
                random_items += 6;
            end else begin
                pick = $urandom_range(99);
                if (pick < 5)
                    w_reg = 11'($urandom_range(1));
                else if (pick < 15)
                    w_reg = 11'($urandom_range(1, 8) * 2 + 1);
                else
                    w_reg = 11'($urandom_range(1, 8) * 2);
                pick = $urandom_range(99);
                if (pick < 5)
                    h_reg = 11'd0;
                else if (pick < 10)
                    h_reg = 11'd1;
                else
                    h_reg = 11'($urandom_range(2, 8));
                random_items += eff_width(w_reg) * eff_height(h_reg);
                run_image(w_reg, h_reg);
            end
        end
        steady_flow = 1'b0;

        if (mismatches == 0 && pending_averages.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
